### hw/rtl/mse_pkg.sv
// Shared types and constants for the MIPS subset execute unit.
package mse_pkg;

  localparam int unsigned NumGpr   = 32;
  localparam int unsigned GprWidth = 64;
  localparam int unsigned GprAddrW = 5;

  localparam logic [31:0] START_PC_RESET = 32'hBFC0_0000;
  localparam logic [31:0] PC_REGION_MASK = 32'hF000_0000;
  localparam logic [GprAddrW-1:0] LINK_REG = 5'd31;
  localparam int unsigned LUI_SHIFT = 16;

  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_J       = 6'h02;
  localparam logic [5:0] OPC_JAL     = 6'h03;
  localparam logic [5:0] OPC_ADDIU   = 6'h09;
  localparam logic [5:0] OPC_LUI     = 6'h0F;
  localparam logic [5:0] OPC_LW      = 6'h23;
  localparam logic [5:0] OPC_SW      = 6'h2B;

  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;

  localparam logic OP_EXEC = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] instr_word;
    logic [31:0] load_data;
  } in_req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic        unknown_instr;
  } out_rsp_t;

  typedef struct packed {
    logic                en;
    logic [GprAddrW-1:0] addr;
    logic [GprWidth-1:0] data;
  } wb_t;

  typedef struct packed {
    logic [31:0]         pc;
    logic                pend;
    logic [GprAddrW-1:0] dest;
  } arch_t;

endpackage

### hw/rtl/mse_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module mse_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/mse_gpr.sv
// General purpose register file: two RAM read ports, valid bits, write forwarding.
module mse_gpr (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    re_i,
  input  logic [4:0]              rs_addr_i,
  input  logic [4:0]              rt_addr_i,
  input  mse_pkg::wb_t            wb_i,
  output logic [63:0]             rs_data_o,
  output logic [63:0]             rt_data_o
);
  import mse_pkg::*;

  logic [NumGpr-1:0]   valid_q;
  logic                rs_vld_q, rt_vld_q;
  logic [GprAddrW-1:0] rs_addr_q, rt_addr_q;
  wb_t                 wbl_q;
  logic [GprWidth-1:0] rs_ram, rt_ram;

  mse_ram #(.Width(GprWidth), .Depth(NumGpr)) u_ram_rs (
    .clk_i   (clk_i),
    .we_i    (wb_i.en),
    .waddr_i (wb_i.addr),
    .wdata_i (wb_i.data),
    .re_i    (re_i),
    .raddr_i (rs_addr_i),
    .rdata_o (rs_ram)
  );

  mse_ram #(.Width(GprWidth), .Depth(NumGpr)) u_ram_rt (
    .clk_i   (clk_i),
    .we_i    (wb_i.en),
    .waddr_i (wb_i.addr),
    .wdata_i (wb_i.data),
    .re_i    (re_i),
    .raddr_i (rt_addr_i),
    .rdata_o (rt_ram)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rs_vld_q  <= 1'b0;
      rt_vld_q  <= 1'b0;
      rs_addr_q <= '0;
      rt_addr_q <= '0;
      wbl_q     <= '0;
    end else begin
      if (wb_i.en) begin
        valid_q[wb_i.addr] <= 1'b1;
        wbl_q              <= wb_i;
      end
      if (re_i) begin
        rs_vld_q  <= valid_q[rs_addr_i];
        rt_vld_q  <= valid_q[rt_addr_i];
        rs_addr_q <= rs_addr_i;
        rt_addr_q <= rt_addr_i;
      end
    end
  end

  // latest write wins over RAM contents; entries never written read zero
  always_comb begin
    if (wbl_q.en && (wbl_q.addr == rs_addr_q)) begin
      rs_data_o = wbl_q.data;
    end else begin
      rs_data_o = rs_vld_q ? rs_ram : '0;
    end
    if (wbl_q.en && (wbl_q.addr == rt_addr_q)) begin
      rt_data_o = wbl_q.data;
    end else begin
      rt_data_o = rt_vld_q ? rt_ram : '0;
    end
  end

endmodule

### hw/rtl/mse_exec.sv
// Instruction decode and execute: result, register write-back and next state.
module mse_exec (
  input  mse_pkg::in_req_t  req_i,
  input  mse_pkg::arch_t    arch_i,
  input  logic [63:0]       a_i,
  input  logic [63:0]       b_i,
  output mse_pkg::out_rsp_t rsp_o,
  output mse_pkg::wb_t      wb_o,
  output mse_pkg::arch_t    arch_o
);
  import mse_pkg::*;

  logic [5:0]  opc, fn;
  logic [4:0]  rt, rd;
  logic [15:0] imm;
  logic [25:0] tgt;
  logic [63:0] simm, agen;
  logic [31:0] pc_inc, jtgt;
  logic        wr;
  logic [4:0]  wr_addr;
  logic [63:0] wr_data;

  always_comb begin
    opc    = req_i.instr_word[31:26];
    rt     = req_i.instr_word[20:16];
    rd     = req_i.instr_word[15:11];
    fn     = req_i.instr_word[5:0];
    imm    = req_i.instr_word[15:0];
    tgt    = req_i.instr_word[25:0];
    simm   = {{48{imm[15]}}, imm};
    agen   = a_i + simm;
    pc_inc = arch_i.pc + 32'd4;
    jtgt   = (arch_i.pc & PC_REGION_MASK) | {4'b0, tgt, 2'b0};

    rsp_o         = '0;
    rsp_o.next_pc = pc_inc;
    arch_o        = arch_i;
    wr            = 1'b0;
    wr_addr       = rd;
    wr_data       = '0;

    if (req_i.op == OP_LOAD) begin
      rsp_o.next_pc = arch_i.pc;
      if (arch_i.pend) begin
        wr          = 1'b1;
        wr_addr     = arch_i.dest;
        wr_data     = {32'b0, req_i.load_data};
        arch_o.pend = 1'b0;
      end
    end else begin
      case (opc)
        OPC_SPECIAL: begin
          case (fn)
            FN_ADDU: begin wr = 1'b1; wr_data = a_i + b_i;    end
            FN_SUBU: begin wr = 1'b1; wr_data = a_i - b_i;    end
            FN_AND:  begin wr = 1'b1; wr_data = a_i & b_i;    end
            FN_OR:   begin wr = 1'b1; wr_data = a_i | b_i;    end
            FN_XOR:  begin wr = 1'b1; wr_data = a_i ^ b_i;    end
            FN_NOR:  begin wr = 1'b1; wr_data = ~(a_i | b_i); end
            FN_JR:   rsp_o.next_pc = a_i[31:0];
            default: rsp_o.unknown_instr = 1'b1;
          endcase
        end
        OPC_ADDIU: begin
          wr      = 1'b1;
          wr_addr = rt;
          wr_data = agen;
        end
        OPC_LUI: begin
          wr      = 1'b1;
          wr_addr = rt;
          wr_data = 64'(imm) << LUI_SHIFT;
        end
        OPC_J: rsp_o.next_pc = jtgt;
        OPC_JAL: begin
          wr            = 1'b1;
          wr_addr       = LINK_REG;
          wr_data       = {32'b0, pc_inc};
          rsp_o.next_pc = jtgt;
        end
        OPC_LW: begin
          rsp_o.mem_addr = agen[31:0];
          rsp_o.mem_read = 1'b1;
          arch_o.pend    = 1'b1;
          arch_o.dest    = rt;
        end
        OPC_SW: begin
          rsp_o.mem_addr  = agen[31:0];
          rsp_o.mem_wdata = b_i[31:0];
          rsp_o.mem_write = 1'b1;
        end
        default: rsp_o.unknown_instr = 1'b1;
      endcase
    end

    arch_o.pc = rsp_o.next_pc;
    wb_o.en   = wr && (wr_addr != '0);
    wb_o.addr = wr_addr;
    wb_o.data = wr_data;
  end

endmodule

### hw/rtl/mips_subset_execute_unit_top.sv
// MIPS subset execute unit: top level with pipeline control and APB register.
//
// Input channel (in_valid_i/in_ready_o, in_req_i) takes one request per cycle
// while in_ready_o is high: op selects between executing instr_word and
// returning load_data for the pending LW. Output channel (out_valid_o/
// out_ready_i, out_rsp_o) gives exactly one response per request, in order.
// Accepted requests wait in the execute stage; responses are registered as it
// advances, one per cycle unless the receiver stalls. The register file sits
// in two 32x64 RAMs with a registered read; the read is issued at accept and
// the last write-back is forwarded, so dependent requests still issue back to back.
// The APB port holds start_pc at address 0; a write also reloads the PC.
// Reset: start_pc and PC go to 0xBFC00000, no load pending, and all registers
// read zero at once (per-entry valid bits, no clearing pass).
// When the receiver stalls, the response holds in the output register, one more
// request is held in the execute stage, and then in_ready_o drops.
module mips_subset_execute_unit_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mse_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mse_pkg::out_rsp_t  out_rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mse_pkg::*;

  logic        s1_valid_q;
  in_req_t     s1_req_q;
  logic        out_valid_q;
  out_rsp_t    out_rsp_q;
  arch_t       arch_q, arch_d;
  logic [31:0] start_pc_q;
  logic        s1_adv, in_acc, cfg_wr;
  logic [63:0] rs_data, rt_data;
  out_rsp_t    rsp;
  wb_t         wb, wb_gated;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign cfg_wr     = psel && penable && pwrite && pready;

  mse_gpr u_gpr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (in_acc),
    .rs_addr_i (in_req_i.instr_word[25:21]),
    .rt_addr_i (in_req_i.instr_word[20:16]),
    .wb_i      (wb_gated),
    .rs_data_o (rs_data),
    .rt_data_o (rt_data)
  );

  mse_exec u_exec (
    .req_i  (s1_req_q),
    .arch_i (arch_q),
    .a_i    (rs_data),
    .b_i    (rt_data),
    .rsp_o  (rsp),
    .wb_o   (wb),
    .arch_o (arch_d)
  );

  always_comb begin
    wb_gated    = wb;
    wb_gated.en = wb.en && s1_adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      start_pc_q  <= START_PC_RESET;
      arch_q.pc   <= START_PC_RESET;
      arch_q.pend <= 1'b0;
      arch_q.dest <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        start_pc_q <= pwdata;
        arch_q.pc  <= pwdata;
      end else if (s1_adv) begin
        arch_q <= arch_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q <= in_req_i;
    end
    if (s1_adv) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign prdata      = (paddr == 2'd0) ? start_pc_q : start_pc_q;
  assign pready      = 1'b1;

endmodule

### hw/rtl/mse_checker.sv
// Port-level assertions for the MIPS subset execute unit, bound to the top level.
module mse_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input mse_pkg::out_rsp_t out_rsp_o
);
  import mse_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response dropped or changed while stalled");

  a_one_mem_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.mem_read && out_rsp_o.mem_write))
    else $error("load and store issued together");

  a_unknown_no_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.unknown_instr |-> !out_rsp_o.mem_read && !out_rsp_o.mem_write)
    else $error("unknown instruction issued a memory request");

  a_idle_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.mem_read && !out_rsp_o.mem_write |->
      out_rsp_o.mem_addr == '0)
    else $error("memory address set without a request");

  a_wdata_store_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.mem_write |-> out_rsp_o.mem_wdata == '0)
    else $error("write data set without a store");

endmodule

bind mips_subset_execute_unit_top mse_checker u_mse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
